// ===== rtl/core/crc15pec_pkg.sv =====
// Package with item types, constants and the CRC-15 table function for the PEC engine.
package crc15pec_pkg;

    localparam logic [14:0] PEC_SEED = 15'd16;
    localparam logic [14:0] PEC_POLY = 15'h4599;
    localparam int          QUEUE_DEPTH = 4;
    localparam int          MAX_RESULTS = 3;

    localparam logic MODE_GENERATE = 1'b0;
    localparam logic MODE_CHECK    = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic       frame_end;
    } pec_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       is_check_report;
        logic       code_matches;
    } pec_out_t;

    // Table entry: eight bitwise CRC steps of idx << 7, kept to 15 bits.
    function automatic logic [14:0] pec_table_entry(input logic [7:0] idx);
        logic [14:0] t;
        t = {idx, 7'd0};
        for (int k = 0; k < 8; k++)
        begin
            if (t[14])
                t = {t[13:0], 1'b0} ^ PEC_POLY;
            else
                t = {t[13:0], 1'b0};
        end
        return t;
    endfunction

    // One byte of remainder update.
    function automatic logic [14:0] pec_feed(input logic [14:0] rem, input logic [7:0] b);
        logic [7:0] idx;
        idx = rem[14:7] ^ b;
        return {rem[6:0], 8'd0} ^ pec_table_entry(idx);
    endfunction

endpackage

// ===== rtl/core/crc15_pec_frame_engine.sv =====
// Top level of the byte-serial CRC-15 packet error code engine.
//
//   Channel | Handshake            | Payload   | Direction
//   --------+----------------------+-----------+----------
//   input   | in_valid / in_ready  | in_data   | into block
//   output  | out_valid / out_ready| out_data  | out of block
//
// An item is processed in the cycle it is accepted: the remainder and the
// hold are updated at once and its results land in a four-entry result queue.
// A byte that yields one result or none can be accepted every cycle while at
// most one result is pending. A generate-mode frame end puts three results in
// the queue, which the single output port drains one at a time, so input
// waits until at most one is pending. Reset seeds the remainder with 16,
// clears the hold, empties the queue. Output stalls fill it and can hold input.
module crc15_pec_frame_engine
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  crc15pec_pkg::pec_in_t  in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output crc15pec_pkg::pec_out_t out_data
);
    import crc15pec_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Frame state.
    logic [14:0] rem_reg, rem_next;
    logic [7:0]  held0_reg, held0_next;
    logic [7:0]  held1_reg, held1_next;
    logic [1:0]  hcnt_reg, hcnt_next;

    // Result queue; entry 0 is the head.
    pec_out_t    q_reg [QUEUE_DEPTH];
    pec_out_t    q_next [QUEUE_DEPTH];
    logic [CW-1:0] count_reg, count_next;

    // Results produced by the item being accepted.
    pec_out_t    res [MAX_RESULTS];
    logic [1:0]  n_push;

    logic        accept;
    logic        pop;
    logic [14:0] rem_fed;
    logic [14:0] rem_chk;
    logic [15:0] code;
    logic [15:0] chk_code;
    logic        match;

    assign in_ready  = (count_reg <= CW'(1));
    assign out_valid = (count_reg != '0);
    assign out_data  = q_reg[0];
    assign accept    = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Per-item logic: one table lookup and update of the remainder, then the
    // compare against the held pair in check mode.
    always_comb
    begin
        rem_next   = rem_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        hcnt_next  = hcnt_reg;
        n_push     = 2'd0;
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            res[k] = '0;
        end

        rem_fed  = pec_feed(rem_reg, in_data.data_byte);
        code     = {rem_fed, 1'b0};
        rem_chk  = rem_reg;
        chk_code = '0;
        match    = 1'b0;

        if (accept)
        begin
            if (in_data.mode == MODE_GENERATE)
            begin
                res[0].out_byte = in_data.data_byte;
                if (in_data.frame_end)
                begin
                    res[1].out_byte = code[15:8];
                    res[2].out_byte = code[7:0];
                    res[2].out_last = 1'b1;
                    n_push     = 2'd3;
                    rem_next   = PEC_SEED;
                    held0_next = '0;
                    held1_next = '0;
                    hcnt_next  = '0;
                end
                else
                begin
                    n_push   = 2'd1;
                    rem_next = rem_fed;
                end
            end
            else
            begin
                // Check mode: once two bytes are held, the older one leaves the hold and is coded.
                if (hcnt_reg >= 2'd2)
                begin
                    rem_chk    = pec_feed(rem_reg, held0_reg);
                    held0_next = held1_reg;
                    held1_next = in_data.data_byte;
                    hcnt_next  = 2'd3;
                end
                else if (hcnt_reg == 2'd1)
                begin
                    held1_next = in_data.data_byte;
                    hcnt_next  = 2'd2;
                end
                else
                begin
                    held0_next = in_data.data_byte;
                    hcnt_next  = 2'd1;
                end
                rem_next = rem_chk;
                chk_code = {rem_chk, 1'b0};
                match    = (hcnt_next == 2'd3) && (held0_next == chk_code[15:8])
                           && (held1_next == chk_code[7:0]);

                if (in_data.frame_end)
                begin
                    res[0].out_last        = 1'b1;
                    res[0].is_check_report = 1'b1;
                    res[0].code_matches    = match;
                    n_push     = 2'd1;
                    rem_next   = PEC_SEED;
                    held0_next = '0;
                    held1_next = '0;
                    hcnt_next  = '0;
                end
            end
        end
    end

    // Queue update: shift on a pop, then append the new results after the
    // entries that remain.
    always_comb
    begin
        logic [CW-1:0] base;
        base = count_reg - CW'(pop);
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (pop && (i < QUEUE_DEPTH - 1))
                q_next[i] = q_reg[i + 1];
            else
                q_next[i] = q_reg[i];
            for (int k = 0; k < MAX_RESULTS; k++)
            begin
                if ((2'(k) < n_push) && ((base + CW'(k)) == CW'(i)))
                    q_next[i] = res[k];
            end
        end
        count_next = base + CW'(n_push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= PEC_SEED;
            held0_reg <= '0;
            held1_reg <= '0;
            hcnt_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            rem_reg   <= rem_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            hcnt_reg  <= hcnt_next;
            count_reg <= count_next;
        end
    end

    // Queue payload needs no reset; count_reg marks which entries are live.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

// ===== test/crc15_pec_frame_engine_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the byte-serial CRC-15 packet error code frame engine.
module crc15_pec_frame_engine_test;
    import crc15pec_pkg::*;

    // Random part length, per-item wait range and the settle time at the end.
    localparam int RANDOM_ITEMS  = 288;
    localparam int MAX_WAIT      = 10;
    localparam int DRAIN_CYCLES  = 16;
    // The worst case per item is three results, each behind the longest stall,
    // plus the longest input gap, so this limit leaves a wide margin.
    localparam int RUN_LIMIT_NS  = 500000;

    // The hold count reaches this value once two bytes are held and at least
    // one byte has already left the hold and been coded.
    localparam logic [1:0] HOLD_FULL_CODED = 2'd3;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    pec_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    pec_out_t out_data;

    crc15_pec_frame_engine DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Items waiting to be driven, and results the engine still owes us.
    pec_in_t  bytes_to_send[$];
    pec_out_t results_due[$];
    int       mismatch_count = 0;

    // Shadow copy of the engine state: running remainder and the two-byte hold
    // that check mode keeps back for the trailing code.
    logic [14:0] shadow_rem = PEC_SEED;
    logic [7:0]  shadow_hold[0:1] = '{8'h00, 8'h00};
    logic [1:0]  shadow_hold_cnt = 2'd0;

    // Handshake bookkeeping for the rising-edge monitor and the falling-edge
    // drivers. The taken flags are set at one edge and read at the other.
    bit in_taken  = 1'b0;
    bit out_taken = 1'b0;
    bit in_quiet  = 1'b0;
    bit out_quiet = 1'b0;
    int in_gap    = 0;
    int out_stall = 0;

    // Bit-serial CRC-15 update, most significant bit of the byte first. This is
    // the same code the engine builds with its byte table, reached one bit at
    // a time.
    function automatic logic [14:0] crc15_step(input logic [14:0] rem, input logic [7:0] b);
        logic [14:0] r;
        logic        feedback;
        int          i;
        r = rem;
        for (i = 7; i >= 0; i--)
        begin
            feedback = r[14] ^ b[i];
            r = {r[13:0], 1'b0};
            if (feedback)
                r = r ^ PEC_POLY;
        end
        return r;
    endfunction

    // Extreme byte values turn up more often than a flat draw would give.
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
        return 8'($urandom);
    endfunction

    // Any frame end reseeds the remainder and empties the hold, whatever the mode.
    task automatic reseed_frame();
        shadow_rem      = PEC_SEED;
        shadow_hold[0]  = 8'h00;
        shadow_hold[1]  = 8'h00;
        shadow_hold_cnt = 2'd0;
    endtask

    // Works out the results of one accepted item and queues them.
    task automatic predict_pec_item(input pec_in_t item);
        logic [15:0] code;
        pec_out_t    r;
        r = '0;
        if (item.mode == MODE_GENERATE)
        begin
            // Generate bytes are coded at once and echoed; the hold is untouched but for a frame end.
            shadow_rem = crc15_step(shadow_rem, item.data_byte);
            r.out_byte = item.data_byte;
            results_due.push_back(r);
            if (item.frame_end)
            begin
                code = {shadow_rem, 1'b0};
                r.out_byte = code[15:8];
                results_due.push_back(r);
                r.out_byte = code[7:0];
                r.out_last = 1'b1;
                results_due.push_back(r);
                reseed_frame();
            end
        end
        else
        begin
            // Check bytes pass through a two-deep hold; only a byte pushed out of
            // the hold is coded.
            if (shadow_hold_cnt >= 2'd2)
            begin
                shadow_rem      = crc15_step(shadow_rem, shadow_hold[0]);
                shadow_hold[0]  = shadow_hold[1];
                shadow_hold[1]  = item.data_byte;
                shadow_hold_cnt = HOLD_FULL_CODED;
            end
            else if (shadow_hold_cnt == 2'd1)
            begin
                shadow_hold[1]  = item.data_byte;
                shadow_hold_cnt = 2'd2;
            end
            else
            begin
                shadow_hold[0]  = item.data_byte;
                shadow_hold_cnt = 2'd1;
            end
            if (item.frame_end)
            begin
                // A frame too short to carry data plus a code never matches.
                code = {shadow_rem, 1'b0};
                r.out_last        = 1'b1;
                r.is_check_report = 1'b1;
                r.code_matches    = (shadow_hold_cnt == HOLD_FULL_CODED) &&
                                    (shadow_hold[0] == code[15:8]) &&
                                    (shadow_hold[1] == code[7:0]);
                results_due.push_back(r);
                reseed_frame();
            end
        end
    endtask

    // Compares one accepted result with the oldest outstanding prediction.
    task automatic check_result(input pec_out_t got);
        pec_out_t want;
        if (results_due.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: unexpected result byte %02h last %0d report %0d match %0d",
                     $time, got.out_byte, got.out_last, got.is_check_report,
                     got.code_matches);
        end
        else
        begin
            want = results_due.pop_front();
            if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
                got.is_check_report !== want.is_check_report ||
                got.code_matches !== want.code_matches)
            begin
                mismatch_count++;
                $display("%0t: expected byte %02h last %0d report %0d match %0d,",
                         $time, want.out_byte, want.out_last, want.is_check_report,
                         want.code_matches,
                         " got byte %02h last %0d report %0d match %0d",
                         got.out_byte, got.out_last, got.is_check_report,
                         got.code_matches);
            end
        end
    endtask

    task automatic queue_item(input logic mode, input logic [7:0] b, input logic last);
        pec_in_t item;
        item.mode      = mode;
        item.data_byte = b;
        item.frame_end = last;
        bytes_to_send.push_back(item);
    endtask

    task automatic queue_generate_frame(input int len);
        int i;
        for (i = 0; i < len; i++)
            queue_item(MODE_GENERATE, pick_byte(), i == len - 1);
    endtask

    // A check frame of len data bytes followed by their code. When damaged is
    // set, one bit of one byte (data or code) is flipped after the code is
    // computed, so the report must come back as a mismatch.
    task automatic queue_check_frame(input int len, input bit damaged);
        logic [14:0] rem;
        logic [15:0] code;
        logic [7:0]  b;
        logic [7:0]  flip;
        int          victim;
        int          i;
        rem    = PEC_SEED;
        victim = damaged ? $urandom_range(0, len + 1) : -1;
        flip   = 8'h01 << $urandom_range(0, 7);
        for (i = 0; i < len; i++)
        begin
            b   = pick_byte();
            rem = crc15_step(rem, b);
            queue_item(MODE_CHECK, (victim == i) ? (b ^ flip) : b, 1'b0);
        end
        code = {rem, 1'b0};
        queue_item(MODE_CHECK, (victim == len) ? (code[15:8] ^ flip) : code[15:8], 1'b0);
        queue_item(MODE_CHECK, (victim == len + 1) ? (code[7:0] ^ flip) : code[7:0], 1'b1);
    endtask

    // Input side: presents the next item after a random gap and holds it with
    // a steady payload until the engine takes it. Quiet stretches drive items
    // back to back.
    always @(negedge clk)
    begin : drive_input
        logic    nxt_valid;
        pec_in_t nxt_data;
        nxt_valid = in_valid;
        nxt_data  = in_data;
        if (rst_n)
        begin
            if (in_valid && in_taken)
            begin
                nxt_valid = 1'b0;
                in_taken  = 1'b0;
                if ($urandom_range(0, 15) == 0)
                    in_quiet = !in_quiet;
                in_gap = in_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (!nxt_valid)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (bytes_to_send.size() > 0)
                begin
                    nxt_data  = bytes_to_send.pop_front();
                    nxt_valid = 1'b1;
                end
            end
        end
        in_valid <= nxt_valid;
        in_data  <= nxt_data;
    end

    // Output side: after each result taken, back-pressure for a random number
    // of cycles, again with occasional stretches of no stall at all.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                out_taken = 1'b0;
                if ($urandom_range(0, 15) == 0)
                    out_quiet = !out_quiet;
                out_stall = out_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor: every handshake is seen at the rising edge. Accepted inputs feed
    // the shadow model; accepted outputs are checked in order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_pec_item(in_data);
                in_taken = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                check_result(out_data);
                out_taken = 1'b1;
            end
        end
    end

    initial
    begin : run_frames
        int pick;
        int len;
        int i;

        // Directed frames. Single-byte generate frame with the smallest byte.
        queue_item(MODE_GENERATE, 8'h00, 1'b1);
        // Generate frame with the largest byte and single-bit extremes.
        queue_item(MODE_GENERATE, 8'hff, 1'b0);
        queue_item(MODE_GENERATE, 8'h80, 1'b0);
        queue_item(MODE_GENERATE, 8'h01, 1'b1);
        // Short check frame of one byte.
        queue_item(MODE_CHECK, 8'hff, 1'b1);
        // Short check frame of two bytes that happen to equal the empty-frame
        // code; it must still report a mismatch.
        queue_item(MODE_CHECK, 8'h00, 1'b0);
        queue_item(MODE_CHECK, 8'h20, 1'b1);
        // Well-formed check frame, then one with a corrupted byte.
        queue_check_frame(2, 1'b0);
        queue_check_frame(1, 1'b1);
        // Mixed frames: modes share the remainder and the hold, and a
        // generate frame end clears whatever check bytes were held.
        queue_item(MODE_GENERATE, 8'h3c, 1'b0);
        queue_item(MODE_CHECK, 8'hc3, 1'b0);
        queue_item(MODE_CHECK, 8'h7e, 1'b0);
        queue_item(MODE_GENERATE, 8'h81, 1'b1);
        queue_item(MODE_GENERATE, 8'h11, 1'b0);
        queue_item(MODE_CHECK, 8'h22, 1'b0);
        queue_item(MODE_CHECK, 8'h33, 1'b0);
        queue_item(MODE_CHECK, 8'h44, 1'b1);

        // Random frames, mostly well formed so that check reports can match.
        len = bytes_to_send.size() + RANDOM_ITEMS;
        while (bytes_to_send.size() < len)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                queue_generate_frame($urandom_range(1, 8));
            else if (pick < 78)
                queue_check_frame($urandom_range(1, 6), 1'b0);
            else if (pick < 90)
                queue_check_frame($urandom_range(0, 6), 1'b1);
            else if (pick < 95)
            begin
                // Short check frame of one or two random bytes.
                i = $urandom_range(1, 2);
                if (i == 2)
                    queue_item(MODE_CHECK, pick_byte(), 1'b0);
                queue_item(MODE_CHECK, pick_byte(), 1'b1);
            end
            else
            begin
                // Noise: each byte picks its own mode.
                pick = $urandom_range(1, 8);
                for (i = 0; i < pick; i++)
                    queue_item(1'($urandom_range(0, 1)), pick_byte(), i == pick - 1);
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (bytes_to_send.size() > 0 || in_valid || results_due.size() > 0)
            @(posedge clk);
        // Anything the engine still emits after this point is flagged as extra.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (results_due.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: %0d expected results never arrived", $time, results_due.size());
        end
        if (mismatch_count == 0)
            $display("crc15_pec_frame_engine: match");
        else
            $display("crc15_pec_frame_engine: mismatch");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("crc15_pec_frame_engine: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/crc15pec_pkg.sv
rtl/core/crc15_pec_frame_engine.sv
test/crc15_pec_frame_engine_test.sv
